// File: src/adpcmb_pkg.sv
// Shared constants and the step scale table for the ADPCM-B encoder.
// No dependencies; imported by adpcm_b_encoder.
package adpcmb_pkg;

    localparam int unsigned PCM_W      = 16;
    localparam int unsigned PRED_W     = 24;
    localparam int unsigned STEP_W     = 15;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CODE_W     = 3;

    localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX = 15'h5fff;

    localparam logic signed [PRED_W-1:0] PRED_MAX = 24'sh7fffff;
    localparam logic signed [PRED_W-1:0] PRED_MIN = -24'sh800000;

    // Step multiplier in 1/64 units, indexed by magnitude code
    function automatic logic [7:0] step_scale(input logic [CODE_W-1:0] code);
        logic [7:0] f;
        case (code)
            3'd4:    f = 8'd77;
            3'd5:    f = 8'd102;
            3'd6:    f = 8'd128;
            3'd7:    f = 8'd153;
            default: f = 8'd57;
        endcase
        return f;
    endfunction

endpackage

// File: src/adpcm_b_encoder.sv
// ADPCM-B (delta-T) encoder top level: predictor, adaptive step, nibble packing.
// Depends on adpcmb_pkg.
//
// Usage
//  - Input stream: one signed 16-bit PCM sample per transaction on s_axis.
//    tuser set marks the first sample of a clip: predictor, step size and
//    nibble phase return to their reset values before that sample is coded.
//  - Output stream: one code byte on m_axis for every second sample, the
//    earlier sample's nibble in bits 7..4. An odd trailing sample of a clip
//    stays held and is dropped by the next start of clip.
//  - For each sample, the accept cycle forms the difference, the shared
//    compare/subtract unit then produces the 3-bit magnitude code one quotient
//    bit at a time, and the update state updates predictor and step.
//    o_s_axis_tready is high only while the sequencer is idle.
//  - The code byte appears in the output register on the edge that ends the
//    update cycle of the second sample.
//  - A stalled receiver does not hold the input side until a second byte is
//    ready: the update cycle then waits until the output register drains.
//  - i_rst_n (synchronous, active low) returns the coder state to its clip
//    start values and empties the output register.
module adpcm_b_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [adpcmb_pkg::PCM_W-1:0]  i_s_axis_tdata,  // [15:0] pcm_sample
    input  logic                          i_s_axis_tuser,  // [0] start_of_clip
    // master side
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [adpcmb_pkg::BYTE_W-1:0] o_m_axis_tdata   // [7:0] code_byte
);
    import adpcmb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD
    } t_state;

    t_state                    r_state;
    logic signed [PRED_W-1:0]  r_pred;
    logic [STEP_W-1:0]         r_step;
    logic [NIB_W-1:0]          r_held;
    logic                      r_phase;
    logic                      r_sign;
    logic [PRED_W+1:0]         r_rem;    // 4*|d|
    logic [STEP_W+1:0]         r_div;    // step, step*2, step*4
    logic [CODE_W-1:0]         r_code;
    logic [1:0]                r_cnt;
    logic                      r_out_valid;
    logic [BYTE_W-1:0]         r_out_data;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic signed [PRED_W-1:0]  w_pred_eff;
    logic signed [PRED_W:0]    w_d;
    logic [PRED_W-1:0]         w_mag;
    logic [PRED_W+2:0]         w_diff;
    logic                      w_fit;
    logic [NIB_W-1:0]          w_nib;
    logic [STEP_W+3:0]         w_mult;
    logic [STEP_W:0]           w_adj;
    logic signed [PRED_W:0]    w_psum;
    logic signed [PRED_W-1:0]  w_pnew;
    logic [STEP_W+7:0]         w_sprod;
    logic [STEP_W+1:0]         w_sraw;
    logic [STEP_W-1:0]         w_snew;
    logic                      w_emit_ok;
    logic                      w_emit;

    function automatic logic [STEP_W-1:0] start_step(input logic start,
                                                     input logic [STEP_W-1:0] step);
        return start ? STEP_MIN : step;
    endfunction

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = r_out_valid && i_m_axis_tready;

    // Difference against the predictor, with clip start applied first
    assign w_pred_eff = i_s_axis_tuser ? '0 : r_pred;
    assign w_d = {{(PRED_W+1-PCM_W){i_s_axis_tdata[PCM_W-1]}}, i_s_axis_tdata}
               - {w_pred_eff[PRED_W-1], w_pred_eff};
    assign w_mag = w_d[PRED_W] ? PRED_W'(-w_d) : w_d[PRED_W-1:0];

    // Shared compare/subtract unit: one quotient bit per cycle
    assign w_diff = {1'b0, r_rem} - {{(PRED_W+2-STEP_W-1){1'b0}}, r_div};
    assign w_fit  = !w_diff[PRED_W+2];

    // Update path
    assign w_nib  = {r_sign, r_code};
    assign w_mult = {r_code, 1'b1} * r_step;
    assign w_adj  = r_sign ? (STEP_W+1)'((w_mult + 19'd7) >> 3)
                           : (STEP_W+1)'(w_mult >> 3);
    assign w_psum = r_sign
                  ? {r_pred[PRED_W-1], r_pred} - {{(PRED_W-STEP_W){1'b0}}, w_adj}
                  : {r_pred[PRED_W-1], r_pred} + {{(PRED_W-STEP_W){1'b0}}, w_adj};
    // Overflow out of 24 bits shows as the top two sum bits disagreeing
    always_comb begin
        if (w_psum[PRED_W] != w_psum[PRED_W-1]) begin
            w_pnew = w_psum[PRED_W] ? PRED_MIN : PRED_MAX;
        end else begin
            w_pnew = w_psum[PRED_W-1:0];
        end
    end

    assign w_sprod = step_scale(r_code) * r_step;
    assign w_sraw  = w_sprod[STEP_W+7:6];
    always_comb begin
        if (w_sraw > {2'b00, STEP_MAX}) begin
            w_snew = STEP_MAX;
        end else if (w_sraw < {2'b00, STEP_MIN}) begin
            w_snew = STEP_MIN;
        end else begin
            w_snew = w_sraw[STEP_W-1:0];
        end
    end

    // Odd-phase update may only finish once the output register has room
    assign w_emit_ok = !r_phase || !r_out_valid || i_m_axis_tready;
    assign w_emit    = (r_state == ST_UPD) && r_phase && w_emit_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pred      <= '0;
            r_step      <= STEP_MIN;
            r_held      <= '0;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tuser) begin
                            r_pred  <= '0;
                            r_step  <= STEP_MIN;
                            r_held  <= '0;
                            r_phase <= 1'b0;
                        end
                        r_sign  <= w_d[PRED_W];
                        r_rem   <= {w_mag, 2'b00};
                        r_div   <= {start_step(i_s_axis_tuser, r_step), 2'b00};
                        r_code  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_fit) begin
                        r_rem <= w_diff[PRED_W+1:0];
                    end
                    r_code <= {r_code[CODE_W-2:0], w_fit};
                    r_div  <= r_div >> 1;
                    r_cnt  <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (w_emit_ok) begin
                        r_pred <= w_pnew;
                        r_step <= w_snew;
                        if (r_phase) begin
                            r_out_data  <= {r_held, w_nib};
                            r_phase     <= 1'b0;
                        end else begin
                            r_held  <= w_nib;
                            r_phase <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Step size never leaves its clamp range
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step >= STEP_MIN) && (r_step <= STEP_MAX))
        else $error("step size out of range");

    // An accepted sample always starts the quotient iteration
    a_acc_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_DIV) && (r_cnt == 2'd0))
        else $error("accepted sample did not enter division");

    // Iteration counter stays within the three quotient bits
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= 2'd2))
        else $error("division counter overrun");

    // A completed odd-phase update always presents a byte
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) && r_phase && w_emit_ok |=> r_out_valid && !r_phase)
        else $error("code byte not emitted");

endmodule

// File: verif/tb_adpcm_b_encoder.sv
// Self-checking testbench for adpcm_b_encoder: a hand-worked directed table, then random clips.
// Depends on adpcmb_pkg and adpcm_b_encoder; carries its own sample coder to predict code bytes.
module tb_adpcm_b_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import adpcmb_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RST_CYCLES  = 7;
    localparam int N_DIR       = 24;
    localparam int RAND_ITEMS  = 1800;
    localparam int QUIET_ITEMS = 250;    // tail of the run with no idling on either side
    localparam int HOLD_AT     = 600;    // random sample count that triggers the long sink stall
    localparam int DRAIN_AT    = 1200;   // random sample count that forces a full drain
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // Step multipliers in 1/64 units, one byte per magnitude code, code 0 lowest
    localparam logic [63:0] STEP_FACTORS =
        {8'd153, 8'd128, 8'd102, 8'd77, 8'd57, 8'd57, 8'd57, 8'd57};

    typedef enum int {
        WAVE_NOISE,     // full-range random samples
        WAVE_SQUARE,    // full-scale square wave, drives the step size to its ceiling
        WAVE_WIGGLE,    // small jitter round a level, keeps the step at its floor
        WAVE_RAMP,      // constant slope with 16-bit wrap
        WAVE_FLAT,      // constant level, often zero
        WAVE_SCALED,    // random samples at a random amplitude
        WAVE_SCATTER    // random samples with random clip starts
    } t_wave;

    typedef struct packed {
        logic [PCM_W-1:0]  pcm;
        logic              sos;
        logic              hand;    // want holds a hand-worked code byte
        logic [BYTE_W-1:0] want;
    } t_dir_row;

    // Directed table. Only the after-reset, full-scale and dropped-sample bytes are
    // written in by hand; the other rows go through the coder below.
    t_dir_row dir_rows [N_DIR] = '{
        '{16'h0000, 1'b1, 1'b0, 8'h00},  // clip start, zero difference: nibble held
        '{16'h0000, 1'b0, 1'b1, 8'h08},  // predictor rose by step/8, so small negative
        '{16'h7fff, 1'b1, 1'b0, 8'h00},  // positive full scale
        '{16'h8000, 1'b0, 1'b1, 8'h7f},  // negative full scale
        '{16'h7fff, 1'b0, 1'b0, 8'h00},
        '{16'h7fff, 1'b0, 1'b0, 8'h00},
        '{16'h8000, 1'b0, 1'b0, 8'h00},
        '{16'h8000, 1'b0, 1'b0, 8'h00},
        '{16'h0001, 1'b0, 1'b0, 8'h00},
        '{16'hffff, 1'b0, 1'b0, 8'h00},
        '{16'd40,   1'b1, 1'b0, 8'h00},  // code 1
        '{16'hffc4, 1'b0, 1'b0, 8'h00},
        '{16'd80,   1'b1, 1'b0, 8'h00},  // code 2
        '{16'hff9c, 1'b0, 1'b0, 8'h00},
        '{16'd120,  1'b1, 1'b0, 8'h00},  // code 3
        '{16'd140,  1'b0, 1'b0, 8'h00},
        '{16'd160,  1'b1, 1'b0, 8'h00},  // code 5
        '{16'hff42, 1'b0, 1'b0, 8'h00},
        '{16'hff74, 1'b1, 1'b0, 8'h00},  // code 4, negative
        '{16'hff24, 1'b0, 1'b0, 8'h00},
        '{16'd5,    1'b1, 1'b0, 8'h00},  // one-sample clip: nibble left held
        '{16'd200,  1'b1, 1'b1, 8'h00},  // start drops it; code 6 now held
        '{16'hfffb, 1'b0, 1'b1, 8'h6b},  // held 6 joins negative code 3
        '{16'h8ad0, 1'b1, 1'b0, 8'h00}   // trailing odd sample, dropped if the next clip starts cleanly
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [PCM_W-1:0]  i_s_axis_tdata;   // [15:0] pcm_sample
    logic              i_s_axis_tuser;   // [0] start_of_clip
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [BYTE_W-1:0] o_m_axis_tdata;   // [7:0] code_byte

    // Coder state, tracked per accepted sample transaction
    logic signed [PRED_W-1:0] est_pred;
    logic        [STEP_W-1:0] est_step;
    logic        [NIB_W-1:0]  est_held;
    logic                     est_odd;

    logic [BYTE_W-1:0] pending_bytes [$];   // code bytes still owed by the block
    logic [BYTE_W-1:0] want_byte;
    logic [15:0]       nibbles_seen;

    int  mismatches;
    int  bytes_checked;
    int  samples_sent;
    int  clips_sent;
    int  step_ceiling_hits;
    int  step_floor_hits;
    int  cycle_cnt;
    bit  quiet;            // no idling from here on
    bit  long_hold_req;    // sender asks the sink for one long stall
    bit  hold_active;

    adpcm_b_encoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void clear_clip_state();
        est_pred = '0;
        est_step = STEP_MIN;
        est_held = '0;
        est_odd  = 1'b0;
    endfunction

    // Codes one sample; returns 1 when it completes a code byte.
    function automatic logic encode_sample(input logic [PCM_W-1:0] pcm, input logic sos,
                                           output logic [BYTE_W-1:0] code_byte);
        longint            diff;
        longint            mag;
        longint            quo;
        longint            delta;
        longint            next_pred;
        longint            next_step;
        logic [CODE_W-1:0] code;
        logic              neg;
        logic [NIB_W-1:0]  nib;

        if (sos)
            clear_clip_state();

        diff = longint'($signed(pcm)) - longint'(est_pred);
        neg  = (diff < 0);
        mag  = neg ? -diff : diff;
        quo  = (mag * 4) / longint'(est_step);
        code = (quo > 7) ? 3'd7 : quo[CODE_W-1:0];

        // Odd multiple of step/8; >>> on a signed value floors towards minus infinity
        delta = (2 * longint'(code) + 1) * longint'(est_step);
        if (neg)
            delta = -delta;
        next_pred = longint'(est_pred) + (delta >>> 3);
        if (next_pred > longint'(PRED_MAX))
            next_pred = longint'(PRED_MAX);
        if (next_pred < longint'(PRED_MIN))
            next_pred = longint'(PRED_MIN);
        est_pred = next_pred[PRED_W-1:0];

        next_step = (longint'(STEP_FACTORS[code * 8 +: 8]) * longint'(est_step)) >>> 6;
        if (next_step >= longint'(STEP_MAX)) begin
            next_step = longint'(STEP_MAX);
            step_ceiling_hits++;
        end
        if (next_step <= longint'(STEP_MIN)) begin
            next_step = longint'(STEP_MIN);
            step_floor_hits++;
        end
        est_step = next_step[STEP_W-1:0];

        nib = {neg, code};
        nibbles_seen[nib] = 1'b1;
        if (est_odd) begin
            code_byte = {est_held, nib};
            est_odd   = 1'b0;
            return 1'b1;
        end
        code_byte = '0;
        est_held  = nib;
        est_odd   = 1'b1;
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Offers one sample from the falling edge and holds it until a transaction.
    task automatic push_sample(input logic [PCM_W-1:0] pcm, input logic sos,
                               input logic hand, input logic [BYTE_W-1:0] want);
        logic [BYTE_W-1:0] predicted;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pcm;
        i_s_axis_tuser  <= sos;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        if (encode_sample(pcm, sos, predicted))
            pending_bytes.push_back(hand ? want : predicted);
        samples_sent++;
        if (sos)
            clips_sent++;
    endtask

    // Sender idle gap whose length is set by n; junk on the data lines while tvalid is low
    task automatic idle_gap(input int n);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= PCM_W'($urandom);
        i_s_axis_tuser  <= 1'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // Output side: every byte transaction against the oldest owed byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                note_mismatch($sformatf("code byte %02h with none owed", o_m_axis_tdata));
            end else begin
                want_byte = pending_bytes.pop_front();
                bytes_checked++;
                if (o_m_axis_tdata !== want_byte)
                    note_mismatch($sformatf("code byte %0d: expected %02h, got %02h",
                                            bytes_checked, want_byte, o_m_axis_tdata));
            end
        end
    end

    // Sink: tready bursts at a rate picked per segment, plus one long stall on request
    initial begin : sink_ctrl
        int stall_left;
        int hold_left;
        int seg_left;
        int chance;
        stall_left = 0;
        hold_left  = 0;
        seg_left   = 0;
        chance     = 0;
        hold_active = 1'b0;
        i_m_axis_tready = 1'b0;
        while (!i_rst_n)
            @(negedge i_clk);
        forever begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 400);
                case ($urandom_range(0, 3))
                    0: chance = 0;
                    1: chance = 3;
                    2: chance = 12;
                    default: chance = 35;
                endcase
            end else begin
                seg_left--;
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
                hold_active   = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                hold_active = (hold_left != 0);
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < chance) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d code bytes still owed",
                 cycle_cnt, pending_bytes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int               r;
        int               n;
        int               clip_len;
        int               half_per;
        int               slope;
        int               rand_sent;
        int               src_chance;
        t_wave            kind;
        logic [PCM_W-1:0] level;
        logic [PCM_W-1:0] pcm;
        logic             sos;
        logic             broken;
        bit               hold_done;
        bit               drain_done;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        quiet           = 1'b0;
        long_hold_req   = 1'b0;
        nibbles_seen    = '0;
        mismatches      = 0;
        bytes_checked   = 0;
        samples_sent    = 0;
        clips_sent      = 0;
        step_ceiling_hits = 0;
        step_floor_hits   = 0;
        hold_done       = 1'b0;
        drain_done      = 1'b0;
        rand_sent       = 0;
        clear_clip_state();

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIR; r++) begin
            push_sample(dir_rows[r].pcm, dir_rows[r].sos, dir_rows[r].hand, dir_rows[r].want);
            if ($urandom_range(0, 99) < 20)
                idle_gap($urandom_range(1, 19));
        end

        // Random clips. Most start a clip cleanly; a few carry on the previous
        // clip's state and scatter clips start at random points.
        while (rand_sent < RAND_ITEMS) begin
            kind     = t_wave'($urandom_range(0, 6));
            clip_len = (kind == WAVE_SQUARE) ? $urandom_range(20, 64) : $urandom_range(1, 40);
            half_per = $urandom_range(1, 4);
            slope    = $urandom_range(0, 4000) - 2000;
            level    = PCM_W'($urandom);
            if (kind == WAVE_FLAT && $urandom_range(0, 1) == 0)
                level = '0;
            broken   = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
                0: src_chance = 0;
                1: src_chance = 5;
                2: src_chance = 15;
                default: src_chance = 40;
            endcase

            // Long sink stall while samples keep coming: block fills and holds tready low
            if (!hold_done && rand_sent >= HOLD_AT) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            if ((!drain_done && rand_sent >= DRAIN_AT) || $urandom_range(0, 24) == 0) begin
                wait_drained();
                drain_done = 1'b1;
            end

            for (n = 0; n < clip_len && rand_sent < RAND_ITEMS; n++) begin
                sos = (n == 0) && !broken;
                case (kind)
                    WAVE_SQUARE: pcm = ((n / half_per) % 2 == 1) ? 16'h8000 : 16'h7fff;
                    WAVE_WIGGLE: pcm = level + PCM_W'($urandom_range(0, 63)) - 16'd32;
                    WAVE_RAMP: begin
                        pcm   = level;
                        level = level + PCM_W'(slope);
                    end
                    WAVE_FLAT:   pcm = level;
                    WAVE_SCALED: begin
                        pcm = PCM_W'($urandom);
                        pcm = $signed(pcm) >>> $urandom_range(0, 14);
                    end
                    WAVE_SCATTER: begin
                        pcm = PCM_W'($urandom);
                        sos = ($urandom_range(0, 7) == 0);
                    end
                    default: pcm = PCM_W'($urandom);
                endcase
                quiet = (rand_sent >= RAND_ITEMS - QUIET_ITEMS);
                push_sample(pcm, sos, 1'b0, '0);
                rand_sent++;
                if (!quiet && !hold_active && !long_hold_req &&
                    $urandom_range(0, 99) < src_chance)
                    idle_gap($urandom_range(1, 19));
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Coded %0d samples over %0d clip starts, compared %0d code bytes, %0d mismatches.",
                 samples_sent, clips_sent, bytes_checked, mismatches);
        $display("Nibbles seen %016b; step size clamped at ceiling %0d times, at floor %0d times.",
                 nibbles_seen, step_ceiling_hits, step_floor_hits);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
src/adpcmb_pkg.sv
src/adpcm_b_encoder.sv
verif/tb_adpcm_b_encoder.sv
